// File: design/oile_pkg.sv
// Shared types and codes for the ordered integer list engine.
package oile_pkg;

    // Operation codes carried in the func field.
    localparam logic [2:0] FUNC_APPEND = 3'd0;
    localparam logic [2:0] FUNC_READ   = 3'd1;
    localparam logic [2:0] FUNC_POP    = 3'd2;
    localparam logic [2:0] FUNC_FIND   = 3'd3;
    localparam logic [2:0] FUNC_DUMP   = 3'd4;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    // A dump never emits more beats than this.
    localparam int MAX_RES = 16;

    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         position_in;
        logic signed [31:0] data_in;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [3:0]         position_out;
        logic [1:0]         status;
        logic [4:0]         element_count;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_POP,
        ST_SHIFT,
        ST_FIND,
        ST_DUMP
    } t_state;

endpackage

// File: design/ordered_int_list_engine_unit.sv
// Top level of the ordered integer list engine: control sequencer around the list memory.
//
// An append, and any command answered by a status alone, is accepted and its result
// beat appears on the following cycle; busy stays low, so the next command may follow
// at once. A read passes the addressed entry through the read register of the list
// memory and then the result register. A pop emits its value by the same path and then
// stays busy while the entries behind the removed one move down, one entry per cycle.
// A find scans from the head, one element per cycle, until a hit or the last element.
// A dump emits min(count, 16) beats, one beat per cycle, after the read of the head
// entry. This pacing is set by the single read port of the list memory. Result beats
// carry o_valid for exactly one cycle and cannot be held off by the receiver.
module ordered_int_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  oile_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output oile_pkg::t_result o_result
);
    import oile_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_end, n_end;
    logic [31:0]     r_key, n_key;
    t_result         r_out, n_out;
    logic            r_out_vld, n_out_vld;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [31:0]     mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [31:0]     mem_rdata;

    logic            accept;
    logic            is_empty;
    logic            is_full;
    logic            pos_bad;
    logic            at_end;
    logic            hit;
    logic [XW-1:0]   cnt_x;
    logic [AW-1:0]   dump_end;

    oile_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    assign cnt_x    = XW'(r_count);
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(DEPTH));
    assign pos_bad  = (XW'(i_cmd.position_in) >= cnt_x);
    assign at_end   = (r_idx == r_end);
    assign hit      = (mem_rdata == r_key);
    assign dump_end = (cnt_x > XW'(MAX_RES)) ? AW'(MAX_RES - 1) : AW'(r_count - 1'b1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !is_empty) begin
                    case (i_cmd.func)
                        FUNC_READ: if (!pos_bad) n_state = ST_READ;
                        FUNC_POP:  if (!pos_bad) n_state = ST_POP;
                        FUNC_FIND: n_state = ST_FIND;
                        FUNC_DUMP: n_state = ST_DUMP;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:  n_state = ST_IDLE;
            ST_POP:   n_state = at_end ? ST_IDLE : ST_SHIFT;
            ST_SHIFT: if (at_end) n_state = ST_IDLE;
            ST_FIND:  if (hit || at_end) n_state = ST_IDLE;
            ST_DUMP:  if (at_end) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_end     = r_end;
        n_key     = r_key;
        n_out_vld = 1'b0;
        n_out     = '{data_out: '0, position_out: '0, status: STAT_OK,
                      element_count: 5'(r_count), last: 1'b1};
        mem_we    = 1'b0;
        mem_waddr = r_idx - 1'b1;
        mem_wdata = mem_rdata;
        mem_raddr = r_idx + 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.func)
                        FUNC_APPEND: begin
                            n_out_vld = 1'b1;
                            if (is_full) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                mem_we              = 1'b1;
                                mem_waddr           = AW'(r_count);
                                mem_wdata           = i_cmd.data_in;
                                n_count             = r_count + 1'b1;
                                n_out.element_count = 5'(r_count + 1'b1);
                            end
                        end
                        FUNC_READ, FUNC_POP: begin
                            if (is_empty) begin
                                n_out_vld    = 1'b1;
                                n_out.status = STAT_EMPTY;
                            end else if (pos_bad) begin
                                n_out_vld    = 1'b1;
                                n_out.status = STAT_RANGE;
                            end else begin
                                mem_raddr = AW'(i_cmd.position_in);
                                n_idx     = AW'(i_cmd.position_in);
                                n_end     = AW'(r_count - 1'b1);
                                // The count drops now; the pop beat reports the new count.
                                if (i_cmd.func == FUNC_POP) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        FUNC_FIND, FUNC_DUMP: begin
                            if (is_empty) begin
                                n_out_vld    = 1'b1;
                                n_out.status = STAT_EMPTY;
                            end else begin
                                mem_raddr = '0;
                                n_idx     = '0;
                                n_key     = i_cmd.data_in;
                                n_end     = (i_cmd.func == FUNC_DUMP) ? dump_end
                                                                       : AW'(r_count - 1'b1);
                            end
                        end
                        default: n_out_vld = 1'b0;
                    endcase
                end
            end
            ST_READ, ST_POP: begin
                n_out_vld      = 1'b1;
                n_out.data_out = mem_rdata;
                n_idx          = r_idx + 1'b1;
            end
            ST_SHIFT: begin
                // The entry read last cycle moves down one place.
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
            end
            ST_FIND: begin
                n_idx = r_idx + 1'b1;
                if (hit) begin
                    n_out_vld          = 1'b1;
                    n_out.position_out = 4'(r_idx);
                end else if (at_end) begin
                    n_out_vld    = 1'b1;
                    n_out.status = STAT_RANGE;
                end
            end
            ST_DUMP: begin
                n_out_vld          = 1'b1;
                n_out.data_out     = mem_rdata;
                n_out.position_out = 4'(r_idx);
                n_out.last         = at_end;
                n_idx              = r_idx + 1'b1;
            end
            default: n_out_vld = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_end <= n_end;
        r_key <= n_key;
        r_out <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above list depth");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.func == FUNC_APPEND && is_full) |=> $stable(r_count))
        else $error("append on a full list changed the count");

    a_error_beat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != STAT_OK) |-> (o_result.last && o_result.data_out == '0))
        else $error("error beat carries data or is not last");

    a_dump_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=> o_valid)
        else $error("dump stopped before its last beat");

    a_shift_writes_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> (mem_we && mem_waddr < r_idx))
        else $error("shift write not below the entry being read");

endmodule

// File: design/oile_mem.sv
// Simple dual-port list storage with a registered read port.
module oile_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
